### hw/rtl/segisect_pkg.sv
// Shared constants for the 2D segment intersection pipeline.
// Hit kind codes and the tolerance register width; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package segisect_pkg;

	localparam int TOL_BITS  = 16;
	localparam int KIND_BITS = 2;
	localparam logic [TOL_BITS-1:0] TOL_RESET = 16'd1;

	localparam logic [KIND_BITS-1:0] KIND_NONE      = 2'd0;
	localparam logic [KIND_BITS-1:0] KIND_CROSS     = 2'd1;
	localparam logic [KIND_BITS-1:0] KIND_COLLINEAR = 2'd2;

endpackage

`default_nettype wire

### hw/rtl/segment_intersection_2d.sv
// Pipelined fixed-point 2D segment intersection, one result per request.
// Depends on segisect_pkg for hit kind codes and the tolerance width.
//
//   channel | dir | handshake        | payload
//   s_      | in  | tvalid / tready  | tdata: a_start_x, a_start_y, a_end_x, a_end_y,
//           |     |                  |        b_start_x, b_start_y, b_end_x, b_end_y
//   m_      | out | tvalid / tready  | tdata: point_x, point_y; tuser: hit, hit_kind
//   cfg     | in  | tolerance_we     | tolerance_wdata
//
// One request enters per cycle while the output is not stalled; the pipeline depth is set
// by the QB one-bit stages of the two restoring dividers.
// Reset clears all valid bits and sets the tolerance to one.
// A stall at m_tready freezes the whole pipeline; s_tready falls only while the
// output register holds a result that is not taken.
`timescale 1ns / 1ps
`default_nettype none

module segment_intersection_2d
	import segisect_pkg::*;
#(
	parameter int COORD_BITS = 32,
	parameter int FRAC_BITS  = 16
) (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   tolerance_we,
	input  wire  [TOL_BITS-1:0]                   tolerance_wdata,
	input  wire                                   s_tvalid,
	output logic                                  s_tready,
	// a_start_x, a_start_y, a_end_x, a_end_y, b_start_x, b_start_y, b_end_x, b_end_y
	input  wire  [8*COORD_BITS-1:0]               s_tdata,
	output logic                                  m_tvalid,
	input  wire                                   m_tready,
	// point_x, point_y, zero padding
	output logic [((2*COORD_BITS+7)/8)*8-1:0]     m_tdata,
	// hit, hit_kind
	output logic [KIND_BITS:0]                    m_tuser
);

	localparam int C   = COORD_BITS;
	localparam int DW  = C + 1;
	localparam int PW  = 2 * DW;
	localparam int SW  = PW + 2;
	localparam int NW  = SW + FRAC_BITS;
	localparam int QB  = ((FRAC_BITS > TOL_BITS) ? FRAC_BITS : TOL_BITS) + 2;
	localparam int RW  = SW + QB;
	localparam int QW  = QB + 1;
	localparam int TW  = QB + 2;
	localparam int PRW = QW + DW;
	localparam int VW  = PRW + 1;
	localparam int OW  = ((2 * C + 7) / 8) * 8;

	typedef struct packed {
		logic signed [C-1:0]  p1x;
		logic signed [C-1:0]  p1y;
		logic signed [DW-1:0] rx;
		logic signed [DW-1:0] ry;
	} side_t;

	logic [TOL_BITS-1:0] tolerance_q;
	logic                adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tolerance_q <= TOL_RESET;
		end else if (tolerance_we) begin
			tolerance_q <= tolerance_wdata;
		end
	end

	// stage 1: differences
	logic signed [C-1:0] ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
	assign ax0 = s_tdata[0*C +: C];
	assign ay0 = s_tdata[1*C +: C];
	assign ax1 = s_tdata[2*C +: C];
	assign ay1 = s_tdata[3*C +: C];
	assign bx0 = s_tdata[4*C +: C];
	assign by0 = s_tdata[5*C +: C];
	assign bx1 = s_tdata[6*C +: C];
	assign by1 = s_tdata[7*C +: C];

	logic                 vld_s1;
	side_t                sd_s1;
	logic signed [DW-1:0] svx_s1, svy_s1, qpx_s1, qpy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sd_s1.p1x <= ax0;
			sd_s1.p1y <= ay0;
			sd_s1.rx  <= DW'(ax1) - DW'(ax0);
			sd_s1.ry  <= DW'(ay1) - DW'(ay0);
			svx_s1    <= DW'(bx1) - DW'(bx0);
			svy_s1    <= DW'(by1) - DW'(by0);
			qpx_s1    <= DW'(bx0) - DW'(ax0);
			qpy_s1    <= DW'(by0) - DW'(ay0);
		end
	end

	// stage 2: products
	logic                 vld_s2;
	side_t                sd_s2;
	logic signed [PW-1:0] rx_svy_s2, ry_svx_s2, qpx_ry_s2, qpy_rx_s2, qpx_svy_s2, qpy_svx_s2;
	logic signed [PW-1:0] rx_rx_s2, ry_ry_s2, qpx_rx_s2, qpy_ry_s2, svx_rx_s2, svy_ry_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sd_s2      <= sd_s1;
			rx_svy_s2  <= sd_s1.rx * svy_s1;
			ry_svx_s2  <= sd_s1.ry * svx_s1;
			qpx_ry_s2  <= qpx_s1 * sd_s1.ry;
			qpy_rx_s2  <= qpy_s1 * sd_s1.rx;
			qpx_svy_s2 <= qpx_s1 * svy_s1;
			qpy_svx_s2 <= qpy_s1 * svx_s1;
			rx_rx_s2   <= sd_s1.rx * sd_s1.rx;
			ry_ry_s2   <= sd_s1.ry * sd_s1.ry;
			qpx_rx_s2  <= qpx_s1 * sd_s1.rx;
			qpy_ry_s2  <= qpy_s1 * sd_s1.ry;
			svx_rx_s2  <= svx_s1 * sd_s1.rx;
			svy_ry_s2  <= svy_s1 * sd_s1.ry;
		end
	end

	// stage 3: cross and dot products
	logic                 vld_s3;
	side_t                sd_s3;
	logic signed [SW-1:0] rxs_s3, qpxr_s3, qpxs_s3, rr_s3, d0_s3, d1_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sd_s3   <= sd_s2;
			rxs_s3  <= SW'(rx_svy_s2) - SW'(ry_svx_s2);
			qpxr_s3 <= SW'(qpx_ry_s2) - SW'(qpy_rx_s2);
			qpxs_s3 <= SW'(qpx_svy_s2) - SW'(qpy_svx_s2);
			rr_s3   <= SW'(rx_rx_s2) + SW'(ry_ry_s2);
			d0_s3   <= SW'(qpx_rx_s2) + SW'(qpy_ry_s2);
			d1_s3   <= SW'(qpx_rx_s2) + SW'(qpy_ry_s2) + SW'(svx_rx_s2) + SW'(svy_ry_s2);
		end
	end

	// stage 4: classify, select operands, take magnitudes
	logic signed [SW-1:0]         ck;
	logic [2*TOL_BITS-1:0]        tol_sq;
	logic                         rxs_small, qpxr_small, coll_c, bad_c;
	logic signed [SW-1:0]         num_a_sel, num_b_sel, den_sel;
	logic signed [NW-1:0]         num_a_sh, num_b_sh;

	assign ck         = SW'(tolerance_q) << FRAC_BITS;
	assign tol_sq     = tolerance_q * tolerance_q;
	assign rxs_small  = (rxs_s3 < ck) && (rxs_s3 > -ck);
	assign qpxr_small = (qpxr_s3 < ck) && (qpxr_s3 > -ck);
	assign coll_c     = rxs_small && qpxr_small;
	assign bad_c      = coll_c ? ((rr_s3 == '0) || ($unsigned(rr_s3) < SW'(tol_sq)))
	                           : (rxs_small || (rxs_s3 == '0));
	assign num_a_sel  = coll_c ? d0_s3 : qpxs_s3;
	assign num_b_sel  = coll_c ? d1_s3 : qpxr_s3;
	assign den_sel    = coll_c ? rr_s3 : rxs_s3;
	assign num_a_sh   = NW'(num_a_sel) <<< FRAC_BITS;
	assign num_b_sh   = NW'(num_b_sel) <<< FRAC_BITS;

	logic              vld_s4, coll_s4, bad_s4, neg_a_s4, neg_b_s4;
	side_t             sd_s4;
	logic [RW-1:0]     na_s4, nb_s4;
	logic [SW-1:0]     dm_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (adv) begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sd_s4    <= sd_s3;
			coll_s4  <= coll_c;
			bad_s4   <= bad_c;
			neg_a_s4 <= num_a_sh[NW-1] ^ den_sel[SW-1];
			neg_b_s4 <= num_b_sh[NW-1] ^ den_sel[SW-1];
			na_s4    <= RW'(num_a_sh[NW-1] ? $unsigned(-num_a_sh) : $unsigned(num_a_sh));
			nb_s4    <= RW'(num_b_sh[NW-1] ? $unsigned(-num_b_sh) : $unsigned(num_b_sh));
			dm_s4    <= den_sel[SW-1] ? $unsigned(-den_sel) : $unsigned(den_sel);
		end
	end

	// stage 5 and divider: overflow check, then one quotient bit per stage
	logic          vld_s5   [QB+1];
	logic          coll_s5  [QB+1];
	logic          bad_s5   [QB+1];
	logic          neg_a_s5 [QB+1];
	logic          neg_b_s5 [QB+1];
	logic          ovf_a_s5 [QB+1];
	logic          ovf_b_s5 [QB+1];
	side_t         sd_s5    [QB+1];
	logic [RW-1:0] rem_a_s5 [QB+1];
	logic [RW-1:0] rem_b_s5 [QB+1];
	logic [SW-1:0] dm_s5    [QB+1];
	logic [QB-1:0] q_a_s5   [QB+1];
	logic [QB-1:0] q_b_s5   [QB+1];
	logic [RW-1:0] dm_top;

	assign dm_top = RW'(dm_s4) << QB;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5[0] <= 1'b0;
		end else if (adv) begin
			vld_s5[0] <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			coll_s5[0]  <= coll_s4;
			bad_s5[0]   <= bad_s4;
			neg_a_s5[0] <= neg_a_s4;
			neg_b_s5[0] <= neg_b_s4;
			ovf_a_s5[0] <= na_s4 >= dm_top;
			ovf_b_s5[0] <= nb_s4 >= dm_top;
			sd_s5[0]    <= sd_s4;
			rem_a_s5[0] <= na_s4;
			rem_b_s5[0] <= nb_s4;
			dm_s5[0]    <= dm_s4;
			q_a_s5[0]   <= '0;
			q_b_s5[0]   <= '0;
		end
	end

	for (genvar k = 0; k < QB; k++) begin : g_div
		localparam int B = QB - 1 - k;
		logic [RW-1:0] sh;
		logic          ge_a, ge_b;

		assign sh   = RW'(dm_s5[k]) << B;
		assign ge_a = rem_a_s5[k] >= sh;
		assign ge_b = rem_b_s5[k] >= sh;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s5[k+1] <= 1'b0;
			end else if (adv) begin
				vld_s5[k+1] <= vld_s5[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				coll_s5[k+1]  <= coll_s5[k];
				bad_s5[k+1]   <= bad_s5[k];
				neg_a_s5[k+1] <= neg_a_s5[k];
				neg_b_s5[k+1] <= neg_b_s5[k];
				ovf_a_s5[k+1] <= ovf_a_s5[k];
				ovf_b_s5[k+1] <= ovf_b_s5[k];
				sd_s5[k+1]    <= sd_s5[k];
				dm_s5[k+1]    <= dm_s5[k];
				rem_a_s5[k+1] <= ge_a ? (rem_a_s5[k] - sh) : rem_a_s5[k];
				rem_b_s5[k+1] <= ge_b ? (rem_b_s5[k] - sh) : rem_b_s5[k];
				q_a_s5[k+1]   <= q_a_s5[k] | (ge_a ? (QB'(1) << B) : '0);
				q_b_s5[k+1]   <= q_b_s5[k] | (ge_b ? (QB'(1) << B) : '0);
			end
		end
	end

	// stage 6: signed parameters, bound checks, pick t
	logic [QB-1:0]        qa_fin, qb_fin;
	logic signed [TW-1:0] ta, tb, lowb, highb, tlo, thi, tsel;
	logic                 pass_cross, pass_coll, hit_c;

	assign qa_fin = ovf_a_s5[QB] ? '1 : q_a_s5[QB];
	assign qb_fin = ovf_b_s5[QB] ? '1 : q_b_s5[QB];
	assign ta     = neg_a_s5[QB] ? -$signed(TW'(qa_fin)) : $signed(TW'(qa_fin));
	assign tb     = neg_b_s5[QB] ? -$signed(TW'(qb_fin)) : $signed(TW'(qb_fin));
	assign lowb   = -$signed(TW'(tolerance_q));
	assign highb  = $signed(TW'(1) << FRAC_BITS) + $signed(TW'(tolerance_q));
	assign tlo    = (tb < ta) ? tb : ta;
	assign thi    = (tb < ta) ? ta : tb;
	assign pass_cross = (ta >= lowb) && (ta <= highb) && (tb >= lowb) && (tb <= highb);
	assign pass_coll  = !(thi < lowb) && !(tlo > highb);
	assign hit_c  = !bad_s5[QB] && (coll_s5[QB] ? pass_coll : pass_cross);
	assign tsel   = coll_s5[QB] ? (tlo[TW-1] ? '0 : tlo) : ta;

	logic                  vld_s6, hit_s6;
	logic [KIND_BITS-1:0]  kind_s6;
	logic signed [QW-1:0]  t_s6;
	side_t                 sd_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else if (adv) begin
			vld_s6 <= vld_s5[QB];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			hit_s6  <= hit_c;
			kind_s6 <= !hit_c ? KIND_NONE : (coll_s5[QB] ? KIND_COLLINEAR : KIND_CROSS);
			t_s6    <= QW'(tsel);
			sd_s6   <= sd_s5[QB];
		end
	end

	// stage 7: t * r
	logic                  vld_s7, hit_s7;
	logic [KIND_BITS-1:0]  kind_s7;
	logic signed [PRW-1:0] px_s7, py_s7;
	logic signed [C-1:0]   p1x_s7, p1y_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s7 <= 1'b0;
		end else if (adv) begin
			vld_s7 <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			hit_s7  <= hit_s6;
			kind_s7 <= kind_s6;
			px_s7   <= t_s6 * sd_s6.rx;
			py_s7   <= t_s6 * sd_s6.ry;
			p1x_s7  <= sd_s6.p1x;
			p1y_s7  <= sd_s6.p1y;
		end
	end

	// stage 8: add start point, saturate, output register
	logic signed [VW-1:0] vx, vy, vmax, vmin;
	logic signed [C-1:0]  satx, saty;

	assign vx   = VW'(p1x_s7) + VW'(px_s7 >>> FRAC_BITS);
	assign vy   = VW'(p1y_s7) + VW'(py_s7 >>> FRAC_BITS);
	assign vmax = VW'({1'b0, {(C-1){1'b1}}});
	assign vmin = -vmax - VW'(1);
	assign satx = (vx > vmax) ? C'(vmax) : ((vx < vmin) ? C'(vmin) : C'(vx));
	assign saty = (vy > vmax) ? C'(vmax) : ((vy < vmin) ? C'(vmin) : C'(vy));

	logic                 vld_s8, hit_s8;
	logic [KIND_BITS-1:0] kind_s8;
	logic [C-1:0]         point_x_s8, point_y_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s8 <= 1'b0;
		end else if (adv) begin
			vld_s8 <= vld_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			hit_s8     <= hit_s7;
			kind_s8    <= kind_s7;
			point_x_s8 <= hit_s7 ? satx : '0;
			point_y_s8 <= hit_s7 ? saty : '0;
		end
	end

	// advance whenever the output register is empty or being taken
	assign adv      = !vld_s8 || m_tready;
	assign s_tready = adv;
	assign m_tvalid = vld_s8;
	assign m_tdata  = OW'({point_y_s8, point_x_s8});
	assign m_tuser  = {kind_s8, hit_s8};

endmodule

`default_nettype wire

### dv/tb_segment_intersection_2d.sv
// Self-checking testbench for segment_intersection_2d: directed and random segment pairs,
// with a predictor of the hit, its kind and the point, and a result checker.
// Depends on segisect_pkg and the segment_intersection_2d RTL.
`timescale 1ns / 1ps

module tb_segment_intersection_2d;
	import segisect_pkg::*;

	localparam int CB = 32;
	localparam int FB = 16;
	localparam int LATENCY = 26;
	localparam int CYCLE_LIMIT = 400000;

	typedef logic signed [127:0] wide_t;
	typedef logic [7:0][CB-1:0] seg_pair_t;
	typedef struct packed {
		logic                  hit;
		logic [KIND_BITS-1:0]  kind;
		logic [CB-1:0]         px;
		logic [CB-1:0]         py;
	} isect_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   tolerance_we = 1'b0;
	logic [TOL_BITS-1:0]    tolerance_wdata = '0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [8*CB-1:0]        s_tdata = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [2*CB-1:0]        m_tdata;
	logic [KIND_BITS:0]     m_tuser;

	logic [TOL_BITS-1:0]    tol_shadow = TOL_RESET;
	isect_t                 pending_hits[$];
	int                     src_idle = 0;
	int                     snk_idle = 0;
	int                     stall_left = 0;
	int                     cycles = 0;
	int                     errors = 0;
	int                     sent = 0;
	int                     checked = 0;
	int                     n_cross = 0;
	int                     n_coll = 0;

	segment_intersection_2d DUT (
		.clk(clk), .arst_n(arst_n),
		.tolerance_we(tolerance_we), .tolerance_wdata(tolerance_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [CB-1:0] clamp_point(input wide_t base, input wide_t t,
			input wide_t d);
		wide_t v;
		wide_t maxv;
		v = base + ((t * d) >>> FB);
		maxv = (wide_t'(1) <<< (CB - 1)) - 1;
		if (v > maxv)
			return maxv[CB-1:0];
		if (v < -maxv - 1)
			return CB'(-maxv - 1);
		return v[CB-1:0];
	endfunction

	function automatic isect_t predict_intersection(input seg_pair_t p,
			input logic [TOL_BITS-1:0] tolv);
		wide_t c[8];
		wide_t rx, ry, sx, sy, qx, qy, rxs, qpxr, ck, tol, one, rr, d0, d1, t0, t1, lo, hi;
		wide_t tq, uq, t;
		isect_t res;
		res = '0;
		for (int i = 0; i < 8; i++)
			c[i] = $signed(p[i]);
		rx = c[2] - c[0];
		ry = c[3] - c[1];
		sx = c[6] - c[4];
		sy = c[7] - c[5];
		qx = c[4] - c[0];
		qy = c[5] - c[1];
		tol = $signed({1'b0, tolv});
		one = wide_t'(1) <<< FB;
		ck = tol <<< FB;
		rxs = rx * sy - ry * sx;
		qpxr = qx * ry - qy * rx;
		if (rxs < ck && rxs > -ck && qpxr < ck && qpxr > -ck) begin
			rr = rx * rx + ry * ry;
			if (rr == 0 || rr < tol * tol)
				return res;
			d0 = qx * rx + qy * ry;
			d1 = d0 + sx * rx + sy * ry;
			t0 = (d0 <<< FB) / rr;
			t1 = (d1 <<< FB) / rr;
			lo = (t1 < t0) ? t1 : t0;
			hi = (t1 < t0) ? t0 : t1;
			if (hi < -tol || lo > one + tol)
				return res;
			t = (lo < 0) ? wide_t'(0) : lo;
			res.kind = KIND_COLLINEAR;
		end else begin
			if ((rxs < ck && rxs > -ck) || rxs == 0)
				return res;
			tq = ((qx * sy - qy * sx) <<< FB) / rxs;
			uq = (qpxr <<< FB) / rxs;
			if (tq < -tol || tq > one + tol || uq < -tol || uq > one + tol)
				return res;
			t = tq;
			res.kind = KIND_CROSS;
		end
		res.hit = 1'b1;
		res.px = clamp_point(c[0], t, rx);
		res.py = clamp_point(c[1], t, ry);
		return res;
	endfunction

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb_segment_intersection_2d failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (stall_left > 0)
			stall_left <= stall_left - 1;
		m_tready <= arst_n && stall_left <= 1 && ($urandom_range(99) >= snk_idle);
	end

	always @(posedge clk) begin
		isect_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_hits.size() == 0) begin
				$error("unexpected result: tuser %h tdata %h", m_tuser, m_tdata);
				errors++;
			end else begin
				want = pending_hits.pop_front();
				checked++;
				if (m_tuser[0] !== want.hit) begin
					$error("hit: expected %0d, got %0d", want.hit, m_tuser[0]);
					errors++;
				end
				if (m_tuser[KIND_BITS:1] !== want.kind) begin
					$error("hit_kind: expected %0d, got %0d", want.kind, m_tuser[KIND_BITS:1]);
					errors++;
				end
				if (m_tdata[CB-1:0] !== want.px) begin
					$error("point_x: expected %h, got %h", want.px, m_tdata[CB-1:0]);
					errors++;
				end
				if (m_tdata[2*CB-1:CB] !== want.py) begin
					$error("point_y: expected %h, got %h", want.py, m_tdata[2*CB-1:CB]);
					errors++;
				end
			end
		end
	end

	task automatic send_request(input seg_pair_t p);
		isect_t want;
		while ($urandom_range(99) < src_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= p;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		want = predict_intersection(p, tol_shadow);
		if (want.kind == KIND_CROSS)
			n_cross++;
		if (want.kind == KIND_COLLINEAR)
			n_coll++;
		pending_hits.push_back(want);
		sent++;
	endtask

	task automatic drain;
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_hits.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic set_tolerance(input logic [TOL_BITS-1:0] v);
		tolerance_we <= 1'b1;
		tolerance_wdata <= v;
		@(posedge clk);
		tolerance_we <= 1'b0;
		tol_shadow = v;
		@(posedge clk);
	endtask

	function automatic seg_pair_t make_pair(input int ax, input int ay, input int bx,
			input int by, input int cx, input int cy, input int dx, input int dy);
		seg_pair_t p;
		p[0] = ax; p[1] = ay; p[2] = bx; p[3] = by;
		p[4] = cx; p[5] = cy; p[6] = dx; p[7] = dy;
		return p;
	endfunction

	function automatic seg_pair_t random_pair;
		seg_pair_t p;
		int ax, ay, dx, dy, k, m, sc;
		int sel;
		sel = $urandom_range(99);
		sc = 1 << $urandom_range(8, 22);
		ax = $signed($urandom_range(2 * sc)) - sc;
		ay = $signed($urandom_range(2 * sc)) - sc;
		dx = $signed($urandom_range(2 * sc)) - sc;
		dy = $signed($urandom_range(2 * sc)) - sc;
		if (sel < 40) begin
			for (int i = 0; i < 8; i++)
				p[i] = $signed($urandom_range(2 * sc)) - sc;
		end else if (sel < 60) begin
			dx = dx >>> 4;
			dy = dy >>> 4;
			k = $signed($urandom_range(8)) - 3;
			m = $signed($urandom_range(8)) - 3;
			p = make_pair(ax, ay, ax + 4 * dx, ay + 4 * dy,
				ax + k * dx, ay + k * dy, ax + m * dx, ay + m * dy);
		end else if (sel < 70) begin
			p = make_pair(ax, ay, ax + dx, ay + dy, ax + 7, ay - 5, ax + dx + 7, ay + dy - 5);
		end else begin
			for (int i = 0; i < 8; i++)
				p[i] = $urandom;
		end
		return p;
	endfunction

	task automatic test_directed;
		int one;
		one = 1 << FB;
		send_request(make_pair(0, 0, 2 * one, 2 * one, 0, 2 * one, 2 * one, 0));
		send_request(make_pair(0, 0, one, 0, one, 0, one, one));
		send_request(make_pair(0, 0, one, 0, 0, one, one, one));
		send_request(make_pair(0, 0, 4 * one, 0, one, 0, 6 * one, 0));
		send_request(make_pair(0, 0, one, 0, 3 * one, 0, 5 * one, 0));
		send_request(make_pair(0, 0, 4 * one, 0, -2 * one, 0, one, 0));
		send_request(make_pair(one, one, one, one, one, one, 2 * one, one));
		send_request(make_pair(0, 0, 0, 0, 0, 0, 0, 0));
		send_request(make_pair(0, 0, one, one, 2 * one, 0, 2 * one + 1, -one));
		send_request(make_pair(0, 0, one, 0, one + 1, -one, one + 1, one));
		send_request(make_pair(32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000,
			32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000));
		send_request(make_pair(32'h80000000, 0, 32'h7fffffff, 0, 0, 32'h80000000,
			0, 32'h7fffffff));
		send_request(make_pair(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
			32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff));
		send_request(make_pair(32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
			32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff));
		send_request(make_pair(32'h7fff0000, 0, 32'h80000000, 0, -one, -one, one, one));
		send_request(make_pair(0, 0, 2, 0, 0, 0, 2, 0));
		send_request(make_pair(-one, -one, -3 * one, -3 * one, -2 * one, 0, -2 * one, -4 * one));
		drain();
	endtask

	task automatic test_tolerance_extremes;
		int one;
		one = 1 << FB;
		set_tolerance('0);
		send_request(make_pair(0, 0, 4 * one, 0, one, 0, 6 * one, 0));
		send_request(make_pair(0, 0, one, 0, 0, one, one, one));
		send_request(make_pair(0, 0, one, 0, one + 1, -one, one + 1, one));
		drain();
		set_tolerance('1);
		send_request(make_pair(0, 0, one, 0, one + 1, -one, one + 1, one));
		send_request(make_pair(0, 0, one, one, 0, 2, one, one + 2));
		send_request(make_pair(0, 0, 2, 0, 0, 0, 2, 0));
		drain();
	endtask

	task automatic test_backpressure;
		stall_left = 300;
		for (int i = 0; i < 80; i++)
			send_request(random_pair());
		drain();
	endtask

	task automatic test_random_phase(input int src, input int snk, input int n);
		src_idle = src;
		snk_idle = snk;
		for (int i = 0; i < n; i++) begin
			if (i % 150 == 149) begin
				drain();
				case ($urandom_range(3))
					0: set_tolerance(TOL_RESET);
					1: set_tolerance('0);
					2: set_tolerance('1);
					default: set_tolerance(TOL_BITS'($urandom_range(1, 4096)));
				endcase
			end
			send_request(random_pair());
		end
		drain();
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_directed();
		test_tolerance_extremes();
		set_tolerance(TOL_RESET);
		test_backpressure();
		test_random_phase(36, 52, 580);
		test_random_phase(52, 36, 580);
		test_random_phase(0, 0, 580);
		drain();
		$display("%0d segment pairs checked over reset, zero, full and random tolerances;",
			checked);
		$display("%0d proper crossings and %0d collinear overlaps seen", n_cross, n_coll);
		if (errors == 0 && pending_hits.size() == 0) begin
			$display("tb_segment_intersection_2d passed");
		end else begin
			$display("tb_segment_intersection_2d failed");
		end
		$finish;
	end

endmodule

### sim.f
hw/rtl/segisect_pkg.sv
hw/rtl/segment_intersection_2d.sv
dv/tb_segment_intersection_2d.sv
